>>> src/mcas_pkg.sv
// Package for the min-cost assignment solver: defaults, controller states, command/status types.
package mcas_pkg;

  localparam int MAX_ROWS_DEF  = 16;
  localparam int MAX_COLS_DEF  = 16;
  localparam int COST_BITS_DEF = 16;

  localparam int IDX_W   = 4;   // row/column index fields
  localparam int SIZE_W  = 5;   // size registers
  localparam int TOTAL_W = 20;  // reported total
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(1);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_START,
    ST_ROW_INIT,
    ST_LOOP,
    ST_SCAN_TEST,
    ST_SCAN_CAND,
    ST_SCAN_UPD,
    ST_UPD,
    ST_AUG,
    ST_NEXT_ROW,
    ST_FINISH,
    ST_ASSIGN,
    ST_EMIT,
    ST_EMIT_ERR
  } mcas_state_t;

  typedef struct packed {
    logic load;
    logic start;
    logic row_init;
    logic loop_visit;
    logic scan_skip;
    logic scan_done;
    logic scan_cand;
    logic scan_upd;
    logic upd_step;
    logic aug_step;
    logic next_row;
    logic finish;
    logic assign_step;
    logic emit_next;
  } mcas_cmd_t;

  typedef struct packed {
    logic err;
    logic j0_free;
    logic scan_end;
    logic cur_visited;
    logic j1_ok;
    logic upd_last;
    logic aug_more;
    logic rows_last;
    logic assign_last;
    logic emit_last;
  } mcas_sts_t;

endpackage

>>> src/min_cost_assignment_solver_core.sv
// Top level of the min-cost assignment solver: config registers, controller, datapath.
//
// Channel  Signals                                   Moves
// item     item_valid/item_ready + row_index,        one cost entry per request
//          col_index, cost, last_entry
// result   result_valid/result_ready + out_row,      one row assignment per request
//          assigned_column, total_cost, last_result,
//          config_error
// cfg      cfg_valid/cfg_ready + cfg_index, cfg_data register write, always ready
//
// Entries are taken while idle. The solve after the last entry runs as search steps:
// each step has a visit, then per unvisited column a memory read, reduced cost and
// slack/min update, a skip per visited column, a scan close and the potential update
// over columns 0..nc. Row phase i takes at most i+1 steps; then the row table is built.
// Results then drain one per cycle as result_ready allows; the rows-exceed-columns
// case gives one result at once. Reset clears the controller state and the error flag
// and sets both size registers to 16; the cost memory holds whatever was last written.
// While solving or draining results, item_ready stays low.
module min_cost_assignment_solver_core #(
  parameter int MAX_ROWS  = mcas_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS  = mcas_pkg::MAX_COLS_DEF,
  parameter int COST_BITS = mcas_pkg::COST_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic [mcas_pkg::IDX_W-1:0]          row_index,
  input  logic [mcas_pkg::IDX_W-1:0]          col_index,
  input  logic signed [COST_BITS-1:0]         cost,
  input  logic                                last_entry,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic [mcas_pkg::IDX_W-1:0]          out_row,
  output logic [mcas_pkg::IDX_W-1:0]          assigned_column,
  output logic signed [mcas_pkg::TOTAL_W-1:0] total_cost,
  output logic                                last_result,
  output logic                                config_error,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mcas_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [mcas_pkg::SIZE_W-1:0]         cfg_data
);

  logic [mcas_pkg::SIZE_W-1:0] rows_in_use;
  logic [mcas_pkg::SIZE_W-1:0] cols_in_use;
  mcas_pkg::mcas_cmd_t         cmd;
  mcas_pkg::mcas_sts_t         sts;

  // config writes are to land only while idle; the block does not enforce it, and they are always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= mcas_pkg::SIZE_W'(16);
      cols_in_use <= mcas_pkg::SIZE_W'(16);
    end else if (cfg_valid) begin
      case (cfg_index)
        mcas_pkg::REG_ROWS: rows_in_use <= cfg_data;
        mcas_pkg::REG_COLS: cols_in_use <= cfg_data;
        default: ;  // unknown index: dropped
      endcase
    end
  end

  mcas_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .last_entry   (last_entry),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .sts          (sts),
    .cmd          (cmd)
  );

  mcas_dp #(
    .MAX_ROWS  (MAX_ROWS),
    .MAX_COLS  (MAX_COLS),
    .COST_BITS (COST_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .sts             (sts),
    .rows_cfg        (rows_in_use),
    .cols_cfg        (cols_in_use),
    .row_index       (row_index),
    .col_index       (col_index),
    .cost            (cost),
    .out_row         (out_row),
    .assigned_column (assigned_column),
    .total_cost      (total_cost),
    .last_result     (last_result),
    .config_error    (config_error)
  );

endmodule

>>> src/mcas_ctrl.sv
// Controller state machine for the min-cost assignment solver.
module mcas_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  logic                last_entry,
  output logic                result_valid,
  input  logic                result_ready,
  input  mcas_pkg::mcas_sts_t sts,
  output mcas_pkg::mcas_cmd_t cmd
);

  mcas_pkg::mcas_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mcas_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd          = '0;
    item_ready   = 1'b0;
    result_valid = 1'b0;
    case (state)
      mcas_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          cmd.load = 1'b1;
          if (last_entry) state_next = mcas_pkg::ST_START;
        end
      end
      mcas_pkg::ST_START: begin
        cmd.start  = 1'b1;
        state_next = sts.err ? mcas_pkg::ST_EMIT_ERR : mcas_pkg::ST_ROW_INIT;
      end
      mcas_pkg::ST_ROW_INIT: begin
        cmd.row_init = 1'b1;
        state_next   = mcas_pkg::ST_LOOP;
      end
      mcas_pkg::ST_LOOP: begin
        if (sts.j0_free) begin
          state_next = mcas_pkg::ST_AUG;
        end else begin
          cmd.loop_visit = 1'b1;
          state_next     = mcas_pkg::ST_SCAN_TEST;
        end
      end
      mcas_pkg::ST_SCAN_TEST: begin
        if (sts.scan_end) begin
          cmd.scan_done = 1'b1;
          state_next    = sts.j1_ok ? mcas_pkg::ST_UPD : mcas_pkg::ST_AUG;
        end else if (sts.cur_visited) begin
          cmd.scan_skip = 1'b1;
        end else begin
          state_next = mcas_pkg::ST_SCAN_CAND;
        end
      end
      mcas_pkg::ST_SCAN_CAND: begin
        cmd.scan_cand = 1'b1;
        state_next    = mcas_pkg::ST_SCAN_UPD;
      end
      mcas_pkg::ST_SCAN_UPD: begin
        cmd.scan_upd = 1'b1;
        state_next   = mcas_pkg::ST_SCAN_TEST;
      end
      mcas_pkg::ST_UPD: begin
        cmd.upd_step = 1'b1;
        if (sts.upd_last) state_next = mcas_pkg::ST_LOOP;
      end
      mcas_pkg::ST_AUG: begin
        if (sts.aug_more) begin
          cmd.aug_step = 1'b1;
        end else begin
          state_next = mcas_pkg::ST_NEXT_ROW;
        end
      end
      mcas_pkg::ST_NEXT_ROW: begin
        cmd.next_row = 1'b1;
        state_next   = sts.rows_last ? mcas_pkg::ST_FINISH : mcas_pkg::ST_ROW_INIT;
      end
      mcas_pkg::ST_FINISH: begin
        cmd.finish = 1'b1;
        state_next = mcas_pkg::ST_ASSIGN;
      end
      mcas_pkg::ST_ASSIGN: begin
        cmd.assign_step = 1'b1;
        if (sts.assign_last) state_next = mcas_pkg::ST_EMIT;
      end
      mcas_pkg::ST_EMIT: begin
        result_valid = 1'b1;
        if (result_ready) begin
          if (sts.emit_last) begin
            state_next = mcas_pkg::ST_IDLE;
          end else begin
            cmd.emit_next = 1'b1;
          end
        end
      end
      mcas_pkg::ST_EMIT_ERR: begin
        result_valid = 1'b1;
        if (result_ready) state_next = mcas_pkg::ST_IDLE;
      end
      default: state_next = mcas_pkg::ST_IDLE;
    endcase
  end

endmodule

>>> src/mcas_dp.sv
// Datapath for the min-cost assignment solver: cost memory, potentials, search state.
module mcas_dp #(
  parameter int MAX_ROWS  = mcas_pkg::MAX_ROWS_DEF,
  parameter int MAX_COLS  = mcas_pkg::MAX_COLS_DEF,
  parameter int COST_BITS = mcas_pkg::COST_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mcas_pkg::mcas_cmd_t               cmd,
  output mcas_pkg::mcas_sts_t               sts,
  input  logic [mcas_pkg::SIZE_W-1:0]       rows_cfg,
  input  logic [mcas_pkg::SIZE_W-1:0]       cols_cfg,
  input  logic [mcas_pkg::IDX_W-1:0]        row_index,
  input  logic [mcas_pkg::IDX_W-1:0]        col_index,
  input  logic signed [COST_BITS-1:0]       cost,
  output logic [mcas_pkg::IDX_W-1:0]        out_row,
  output logic [mcas_pkg::IDX_W-1:0]        assigned_column,
  output logic signed [mcas_pkg::TOTAL_W-1:0] total_cost,
  output logic                              last_result,
  output logic                              config_error
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int NRW   = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int PW    = COST_BITS + $clog2(MAX_ROWS + MAX_COLS) + 4;
  localparam int TW    = (PW + 1 > mcas_pkg::TOTAL_W) ? PW + 1 : mcas_pkg::TOTAL_W;
  localparam logic signed [TW-1:0] TMAX = TW'((1 << (mcas_pkg::TOTAL_W - 1)) - 1);
  localparam logic signed [TW-1:0] TMIN = -TMAX - TW'(1);

  // cost store
  logic signed [COST_BITS-1:0] mem [DEPTH];
  logic signed [COST_BITS-1:0] rd_data;
  logic [AW-1:0]               rd_addr;

  // solve state
  logic signed [PW-1:0] u       [MAX_ROWS];
  logic signed [PW-1:0] v       [MAX_COLS+1];
  logic [RW-1:0]        mrow    [MAX_COLS+1];
  logic                 mok     [MAX_COLS+1];
  logic signed [PW-1:0] slack   [MAX_COLS+1];
  logic                 sok     [MAX_COLS+1];
  logic [CW-1:0]        pred    [MAX_COLS+1];
  logic                 pok     [MAX_COLS+1];
  logic                 visited [MAX_COLS+1];
  logic [CW-1:0]        assign_col [MAX_ROWS];

  logic [NRW-1:0]       nr, nr_cfg;
  logic [CW-1:0]        nc, nc_cfg;
  logic [NRW-1:0]       i;
  logic [CW-1:0]        j, j0, j1;
  logic                 j1_ok;
  logic [RW-1:0]        i0;
  logic signed [PW-1:0] delta, cand;
  logic                 delta_ok;
  logic [RW-1:0]        k;
  logic signed [mcas_pkg::TOTAL_W-1:0] total;
  logic                 err;

  logic                 take;
  logic signed [PW-1:0] new_slack;
  logic signed [TW-1:0] neg_v;

  // clamp of the size registers
  always_comb begin
    if (rows_cfg == '0) begin
      nr_cfg = NRW'(1);
    end else if (int'(rows_cfg) > MAX_ROWS) begin
      nr_cfg = NRW'(MAX_ROWS);
    end else begin
      nr_cfg = NRW'(rows_cfg);
    end
    if (cols_cfg == '0) begin
      nc_cfg = CW'(1);
    end else if (int'(cols_cfg) > MAX_COLS) begin
      nc_cfg = CW'(MAX_COLS);
    end else begin
      nc_cfg = CW'(cols_cfg);
    end
  end

  assign rd_addr = AW'(int'(i0) * MAX_COLS + int'(j));

  always_ff @(posedge clk) begin
    if (cmd.load && int'(row_index) < MAX_ROWS && int'(col_index) < MAX_COLS) begin
      mem[AW'(int'(row_index) * MAX_COLS + int'(col_index))] <= cost;
    end
    rd_data <= mem[rd_addr];
  end

  assign take      = !sok[j] || (cand < slack[j]);
  assign new_slack = take ? cand : slack[j];
  assign neg_v     = -TW'(v[nc]);

  always_ff @(posedge clk) begin
    if (rst) begin
      err <= 1'b0;
    end else if (cmd.start) begin
      err <= int'(nr_cfg) > int'(nc_cfg);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      nr  <= nr_cfg;
      nc  <= nc_cfg;
      i   <= '0;
      for (int r = 0; r < MAX_ROWS; r++) u[r] <= '0;
      for (int c = 0; c <= MAX_COLS; c++) begin
        v[c]   <= '0;
        mok[c] <= 1'b0;
      end
    end
    if (cmd.row_init) begin
      for (int c = 0; c <= MAX_COLS; c++) begin
        sok[c]     <= 1'b0;
        pok[c]     <= 1'b0;
        visited[c] <= 1'b0;
      end
      mrow[nc] <= RW'(i);
      mok[nc]  <= 1'b1;
      j0       <= nc;
    end
    if (cmd.loop_visit) begin
      i0           <= mrow[j0];
      visited[j0]  <= 1'b1;
      delta_ok     <= 1'b0;
      j1_ok        <= 1'b0;
      j            <= '0;
    end
    if (cmd.scan_skip) j <= j + CW'(1);
    if (cmd.scan_done) j <= '0;
    if (cmd.scan_cand) begin
      cand <= PW'(rd_data) - u[i0] - v[j];
    end
    if (cmd.scan_upd) begin
      if (take) begin
        slack[j] <= cand;
        sok[j]   <= 1'b1;
        pred[j]  <= j0;
        pok[j]   <= 1'b1;
      end
      if (!delta_ok || new_slack < delta) begin
        delta    <= new_slack;
        delta_ok <= 1'b1;
        j1       <= j;
        j1_ok    <= 1'b1;
      end
      j <= j + CW'(1);
    end
    if (cmd.upd_step) begin
      if (visited[j]) begin
        if (mok[j]) u[mrow[j]] <= u[mrow[j]] + delta;
        v[j] <= v[j] - delta;
      end else if (sok[j]) begin
        slack[j] <= slack[j] - delta;
      end
      if (j == nc) begin
        j0 <= j1;
        j  <= '0;
      end else begin
        j <= j + CW'(1);
      end
    end
    if (cmd.aug_step) begin
      mrow[j0] <= mrow[pred[j0]];
      mok[j0]  <= mok[pred[j0]];
      j0       <= pred[j0];
    end
    if (cmd.next_row) i <= i + NRW'(1);
    if (cmd.finish) begin
      if (neg_v > TMAX) begin
        total <= TMAX[mcas_pkg::TOTAL_W-1:0];
      end else if (neg_v < TMIN) begin
        total <= TMIN[mcas_pkg::TOTAL_W-1:0];
      end else begin
        total <= neg_v[mcas_pkg::TOTAL_W-1:0];
      end
      for (int r = 0; r < MAX_ROWS; r++) assign_col[r] <= '0;
      j <= '0;
      k <= '0;
    end
    if (cmd.assign_step) begin
      if (mok[j]) assign_col[mrow[j]] <= j;
      j <= j + CW'(1);
    end
    if (cmd.emit_next) k <= k + RW'(1);
  end

  always_comb begin
    sts.err         = int'(nr_cfg) > int'(nc_cfg);
    sts.j0_free     = !mok[j0];
    sts.scan_end    = (j == nc);
    sts.cur_visited = visited[j];
    sts.j1_ok       = j1_ok;
    sts.upd_last    = (j == nc);
    sts.aug_more    = (j0 < nc) && pok[j0] && (pred[j0] <= nc);
    sts.rows_last   = (int'(i) + 1 == int'(nr));
    sts.assign_last = (int'(j) + 1 == int'(nc));
    sts.emit_last   = (int'(k) + 1 == int'(nr));
  end

  assign config_error    = err;
  assign out_row         = err ? '0 : mcas_pkg::IDX_W'(k);
  assign assigned_column = err ? '0 : mcas_pkg::IDX_W'(assign_col[k]);
  assign total_cost      = err ? '0 : total;
  assign last_result     = err || (int'(k) + 1 == int'(nr));

endmodule
